// ===== hdl/fpa_pkg.sv =====
// Shared types and constants for the fixed-point ALU.
// Depends on nothing; imported by fpa_div_step and fixed_point_alu.
package fpa_pkg;

	localparam int FRAC_BITS = 8;
	// quotient width: integer magnitude bits plus fraction bits
	localparam int QW = 32 + FRAC_BITS;

	typedef enum logic [3:0] {
		OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
		OP_MIN = 4'd4, OP_MAX = 4'd5, OP_INC = 4'd6, OP_DEC = 4'd7,
		OP_TO_INT = 4'd8, OP_FROM_INT = 4'd9
	} op_t;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_OVF  = 2'd1;
	localparam logic [1:0] ST_DIV0 = 2'd2;

	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	// one request in flight through the pipeline
	typedef struct packed {
		logic [3:0]        op;
		logic [31:0]       simple;   // result of the combinational operations
		logic [1:0]        st;       // status of the combinational operations
		logic              lt;
		logic              eq;
		logic              gt;
		logic              neg_div;
		logic              div0;
		logic              neg_mul;
		logic [63:0]       mmag;     // product, then its magnitude, then rounded
		logic [QW-1:0]     num;      // numerator bits shifting out, quotient in
		logic [31:0]       rem;
		logic [31:0]       den;
	} fpa_item_t;

endpackage

// ===== hdl/fixed_point_alu.sv =====
// Top level of the signed fixed-point ALU.
// Depends on fpa_pkg and fpa_div_step.
//
// Signed Q(32-FRAC_BITS).FRAC_BITS ALU, one request per cycle. Every request
// passes through the same pipeline of QW+3 stages (43 at eight fraction bits):
// one input stage with the multiplier, one division step per quotient bit
// (the restoring divider sets the depth), one quotient rounding stage and the
// output register. The whole pipeline stalls only while the output holds a result
// that is not taken, so throughput is one request per cycle. Products and
// quotients round to nearest, ties away from zero; overflow saturates with
// status 1, division by zero gives 0, status 2.
module fixed_point_alu (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // operand_a[31:0], operand_b[63:32]
	input  logic [3:0]  s_tuser,  // op[3:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // result[31:0], less[32], equal[33],
	                              // greater[34], status[36:35], zero[39:37]
);
	import fpa_pkg::*;

	logic               en;
	logic signed [31:0] a, b;
	fpa_item_t          in_item;
	logic signed [32:0] sum;
	logic signed [63:0] prod;

	fpa_item_t          st_s1;
	logic               v_s1;
	fpa_item_t          div_s [QW];
	logic [QW-1:0]      v_div;
	fpa_item_t          nxt [QW];

	logic [QW:0]        q_rnd_s2;
	fpa_item_t          rnd_s2;
	logic               v_s2;

	logic [31:0]        out_res_s3;
	logic [1:0]         out_st_s3;
	logic               out_lt_s3, out_eq_s3, out_gt_s3;
	logic               v_s3;

	assign en       = !v_s3 || m_tready;
	assign s_tready = en;
	assign a        = s_tdata[31:0];
	assign b        = s_tdata[63:32];
	assign prod     = a * b;

	// decode and run the combinational operations
	always_comb begin
		in_item        = '0;
		in_item.op     = s_tuser;
		in_item.lt     = a < b;
		in_item.eq     = a == b;
		in_item.gt     = a > b;
		in_item.st     = ST_OK;
		in_item.simple = '0;
		sum            = '0;
		case (s_tuser)
			OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
				case (s_tuser)
					OP_ADD:  sum = 33'(a) + 33'(b);
					OP_SUB:  sum = 33'(a) - 33'(b);
					OP_INC:  sum = 33'(a) + 33'sd1;
					default: sum = 33'(a) - 33'sd1;
				endcase
				if (sum[32] != sum[31]) begin
					in_item.st     = ST_OVF;
					in_item.simple = sum[32] ? S32_MIN : S32_MAX;
				end else begin
					in_item.simple = sum[31:0];
				end
			end
			OP_MIN:    in_item.simple = (a < b) ? a : b;
			OP_MAX:    in_item.simple = (a > b) ? a : b;
			OP_TO_INT: in_item.simple = a >>> FRAC_BITS;
			OP_FROM_INT: begin
				if ((a >>> (31 - FRAC_BITS)) != 32'sd0
				    && (a >>> (31 - FRAC_BITS)) != -32'sd1) begin
					in_item.st     = ST_OVF;
					in_item.simple = a[31] ? S32_MIN : S32_MAX;
				end else begin
					in_item.simple = a <<< FRAC_BITS;
				end
			end
			default: in_item.simple = '0;
		endcase
		in_item.neg_div = a[31] ^ b[31];
		in_item.div0    = b == 32'sd0;
		in_item.num     = {(a[31] ? 32'(-a) : 32'(a)), {FRAC_BITS{1'b0}}};
		in_item.rem     = '0;
		in_item.den     = b[31] ? 32'(-b) : 32'(b);
		in_item.mmag    = prod;
		in_item.neg_mul = prod[63];
	end

	// input stage: register operands, decoded results and the product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s1 <= in_item;
		end
	end

	// division chain: one quotient bit per stage, product rounding rides along
	for (genvar k = 0; k < QW; k++) begin : g_div
		fpa_item_t stepped;

		fpa_div_step u_step (
			.item_in  ((k == 0) ? st_s1 : div_s[(k == 0) ? 0 : k-1]),
			.item_out (stepped)
		);

		always_comb begin
			nxt[k] = stepped;
			if (k == 0) begin
				nxt[k].mmag = stepped.neg_mul ? 64'(-stepped.mmag) : stepped.mmag;
			end else if (k == 1) begin
				nxt[k].mmag = 64'((stepped.mmag + (64'd1 << (FRAC_BITS - 1)))
				                  >> FRAC_BITS);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_div[k] <= 1'b0;
			end else if (en) begin
				v_div[k] <= (k == 0) ? v_s1 : v_div[(k == 0) ? 0 : k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_s[k] <= nxt[k];
			end
		end
	end

	// round the quotient: step up when twice the remainder reaches the divisor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_div[QW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rnd_s2   <= div_s[QW-1];
			q_rnd_s2 <= {1'b0, div_s[QW-1].num}
			          + (QW+1)'({div_s[QW-1].rem, 1'b0} >= {1'b0, div_s[QW-1].den});
		end
	end

	// apply sign, saturate and select the result
	logic [31:0] fin_res;
	logic [1:0]  fin_st;
	logic        fin_neg;
	logic        fin_big;
	logic [31:0] fin_mag;

	always_comb begin
		fin_res = rnd_s2.simple;
		fin_st  = rnd_s2.st;
		fin_neg = 1'b0;
		fin_big = 1'b0;
		fin_mag = '0;
		case (rnd_s2.op)
			OP_MUL: begin
				fin_neg = rnd_s2.neg_mul;
				fin_mag = rnd_s2.mmag[31:0];
				fin_big = fin_neg ? (rnd_s2.mmag > 64'h8000_0000)
				                  : (rnd_s2.mmag > 64'h7FFF_FFFF);
			end
			OP_DIV: begin
				fin_neg = rnd_s2.neg_div;
				fin_mag = q_rnd_s2[31:0];
				fin_big = fin_neg ? (q_rnd_s2 > (QW+1)'(33'h0_8000_0000))
				                  : (q_rnd_s2 > (QW+1)'(33'h0_7FFF_FFFF));
			end
			default: fin_mag = '0;
		endcase
		if (rnd_s2.op == OP_MUL || rnd_s2.op == OP_DIV) begin
			if (rnd_s2.op == OP_DIV && rnd_s2.div0) begin
				fin_res = '0;
				fin_st  = ST_DIV0;
			end else if (fin_big) begin
				fin_res = fin_neg ? S32_MIN : S32_MAX;
				fin_st  = ST_OVF;
			end else begin
				fin_res = fin_neg ? 32'(-fin_mag) : fin_mag;
				fin_st  = ST_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_res_s3 <= fin_res;
			out_st_s3  <= fin_st;
			out_lt_s3  <= rnd_s2.lt;
			out_eq_s3  <= rnd_s2.eq;
			out_gt_s3  <= rnd_s2.gt;
		end
	end

	assign m_tvalid = v_s3;
	assign m_tdata  = {3'b000, out_st_s3, out_gt_s3, out_eq_s3, out_lt_s3, out_res_s3};

	// exactly one comparison flag on every delivered result
	a_flags_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $onehot({out_lt_s3, out_eq_s3, out_gt_s3}))
		else $error("comparison flags not one-hot");

	// division by zero always delivers a zero result
	a_div0_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_st_s3 == ST_DIV0) |-> (out_res_s3 == 32'd0))
		else $error("division by zero gave non-zero result");

	// no status code beyond the defined ones
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (out_st_s3 == ST_OK || out_st_s3 == ST_OVF
		              || out_st_s3 == ST_DIV0))
		else $error("undefined status code");

	// a stalled output keeps its result until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(out_res_s3)))
		else $error("stalled result changed");
endmodule

// ===== hdl/fpa_div_step.sv =====
// One radix-2 restoring division step on a pipeline request.
// Depends on fpa_pkg.
module fpa_div_step (
	input  fpa_pkg::fpa_item_t item_in,
	output fpa_pkg::fpa_item_t item_out
);
	import fpa_pkg::*;

	logic [32:0] trial;
	logic        ge;

	// shift in the next numerator bit and subtract the divisor where it fits
	always_comb begin
		trial    = {item_in.rem, item_in.num[QW-1]};
		ge       = trial >= {1'b0, item_in.den};
		item_out = item_in;
		item_out.rem = ge ? 32'(trial - {1'b0, item_in.den}) : trial[31:0];
		item_out.num = {item_in.num[QW-2:0], ge};
	end
endmodule
